/* src/pps_pkg.sv */
// Package: shared types and constants of the preemptive priority scheduler.
package pps_pkg;

    // Field widths of a request and of a result
    localparam int SLOT_W = 4;
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRIO_W = 8;
    localparam int TIME_W = 32;

    // Request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // One task table entry as kept in the slot RAM
    typedef struct packed {
        logic [ARR_W-1:0]  arrival;
        logic [BUR_W-1:0]  burst;
        logic [BUR_W-1:0]  remain;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;    // capture request fields, clear the scan winner
        logic load;     // write the captured task into its slot
        logic scan_rd;  // a slot read is issued this cycle
        logic update;   // run the winner for one unit, advance time
    } t_cmd;

endpackage

/* src/pps_ram.sv */
// Generic single write port RAM with registered read.
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/pps_ctrl.sv */
// Controller: sequences load, slot scan and update of one request.
module pps_ctrl #(
    parameter int SLOTS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_req_type,
    output logic                     o_busy,
    output pps_pkg::t_cmd            o_cmd,
    output logic [$clog2(SLOTS)-1:0] o_rd_addr
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_UPD
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_accept;
    logic          w_scan_end;

    assign w_accept   = i_start && (r_state == ST_IDLE);
    assign w_scan_end = (r_cnt == CW'(SLOTS));

    // Next state and scan counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_state = (i_req_type == pps_pkg::REQ_LOAD) ? ST_LOAD : ST_SCAN;
                end
            end
            ST_LOAD: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                // the final count value issues no read and drains the last registered read
                if (w_scan_end) begin
                    n_state = ST_UPD;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            ST_UPD: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Commands decoded from state
    assign o_busy        = (r_state != ST_IDLE);
    assign o_cmd.latch   = w_accept;
    assign o_cmd.load    = (r_state == ST_LOAD);
    assign o_cmd.scan_rd = (r_state == ST_SCAN) && !w_scan_end;
    assign o_cmd.update  = (r_state == ST_UPD);
    assign o_rd_addr     = r_cnt[SW-1:0];

endmodule

/* src/pps_dp.sv */
// Datapath: slot table, pending bits, scan winner, time counter, results.
module pps_dp #(
    parameter int SLOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pps_pkg::t_cmd               i_cmd,
    input  logic [$clog2(SLOTS)-1:0]    i_rd_addr,
    input  logic [pps_pkg::SLOT_W-1:0]  i_slot,
    input  logic [pps_pkg::ARR_W-1:0]   i_arrival,
    input  logic [pps_pkg::BUR_W-1:0]   i_burst,
    input  logic [pps_pkg::PRIO_W-1:0]  i_prio,
    output logic                        o_valid,
    output logic                        o_ran_valid,
    output logic [pps_pkg::SLOT_W-1:0]  o_ran_slot,
    output logic                        o_finished,
    output logic [pps_pkg::TIME_W-1:0]  o_turnaround,
    output logic [pps_pkg::TIME_W-1:0]  o_waiting,
    output logic                        o_all_done,
    output logic [pps_pkg::TIME_W-1:0]  o_now
);

    localparam int SW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);
    localparam int TW = pps_pkg::TIME_W;
    localparam int EW = $bits(pps_pkg::t_entry);

    // Captured request
    logic [pps_pkg::SLOT_W-1:0] r_slot;
    logic [pps_pkg::ARR_W-1:0]  r_arrival;
    logic [pps_pkg::BUR_W-1:0]  r_burst;
    logic [pps_pkg::PRIO_W-1:0] r_prio;

    // Task state
    logic [SLOTS-1:0]  r_pend;
    logic [PW-1:0]     r_pend_cnt, n_pend_cnt;
    logic [TW-1:0]     r_now, r_now_p1;

    // Scan state
    logic              r_chk_vld;
    logic [SW-1:0]     r_chk_idx;
    logic              r_found;
    logic [SW-1:0]     r_best_idx;
    pps_pkg::t_entry   r_best;
    logic [pps_pkg::ARR_W:0] r_best_end;

    // Result registers
    logic              r_valid;
    logic              r_ran_valid;
    logic [pps_pkg::SLOT_W-1:0] r_ran_slot;
    logic              r_finished;
    logic [TW-1:0]     r_turnaround, r_waiting;
    logic              r_all_done;
    logic [TW-1:0]     r_now_out;

    // RAM port
    logic              w_we;
    logic [SW-1:0]     w_waddr;
    pps_pkg::t_entry   w_wentry;
    pps_pkg::t_entry   w_rentry;
    logic [EW-1:0]     w_rdata;

    logic              w_in_range;
    logic [SW-1:0]     w_ld_idx;
    logic              w_ld_pend;
    logic              w_elig;
    logic              w_fin;

    assign w_in_range = (32'(r_slot) < SLOTS);
    assign w_ld_idx   = SW'(r_slot);
    assign w_ld_pend  = (r_burst != '0);
    assign w_rentry   = pps_pkg::t_entry'(w_rdata);
    assign w_fin      = r_found && (r_best.remain == pps_pkg::BUR_W'(1));

    // Eligibility of the slot whose data the RAM shows this cycle
    assign w_elig = r_chk_vld && r_pend[r_chk_idx]
                    && (TW'(w_rentry.arrival) <= r_now)
                    && (!r_found || (w_rentry.prio < r_best.prio));

    // RAM write: a load writes a fresh entry, an update decrements remain
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = w_ld_idx;
        w_wentry = '{arrival: r_arrival, burst: r_burst, remain: r_burst, prio: r_prio};
        if (i_cmd.load) begin
            w_we = w_in_range;
        end else if (i_cmd.update) begin
            w_we            = r_found;
            w_waddr         = r_best_idx;
            w_wentry        = r_best;
            w_wentry.remain = r_best.remain - pps_pkg::BUR_W'(1);
        end
    end

    pps_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    // Pending count after this request
    always_comb begin
        n_pend_cnt = r_pend_cnt;
        if (i_cmd.load && w_in_range) begin
            n_pend_cnt = r_pend_cnt - PW'(r_pend[w_ld_idx]) + PW'(w_ld_pend);
        end else if (i_cmd.update && w_fin) begin
            n_pend_cnt = r_pend_cnt - PW'(1);
        end
    end

    // Request capture and scan winner (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_slot    <= i_slot;
            r_arrival <= i_arrival;
            r_burst   <= i_burst;
            r_prio    <= i_prio;
        end
        r_chk_idx <= i_rd_addr;
        if (w_elig) begin
            r_best_idx <= r_chk_idx;
            r_best     <= w_rentry;
            r_best_end <= {1'b0, w_rentry.arrival} + {1'b0, w_rentry.burst};
        end
    end

    // Control state: pending bits, count, time, scan flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= '0;
            r_pend_cnt <= '0;
            r_now      <= '0;
            r_now_p1   <= TW'(1);
            r_chk_vld  <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_chk_vld  <= i_cmd.scan_rd;
            r_pend_cnt <= n_pend_cnt;
            if (i_cmd.latch) begin
                r_found <= 1'b0;
            end else if (w_elig) begin
                r_found <= 1'b1;
            end
            if (i_cmd.load && w_in_range) begin
                r_pend[w_ld_idx] <= w_ld_pend;
            end
            if (i_cmd.update) begin
                r_now    <= r_now_p1;
                r_now_p1 <= r_now_p1 + TW'(1);
                if (w_fin) begin
                    r_pend[r_best_idx] <= 1'b0;
                end
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.load || i_cmd.update;
        end
    end

    // Result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ran_valid  <= 1'b0;
            r_ran_slot   <= '0;
            r_finished   <= 1'b0;
            r_turnaround <= '0;
            r_waiting    <= '0;
            r_all_done   <= (n_pend_cnt == '0);
            r_now_out    <= r_now;
        end else if (i_cmd.update) begin
            r_ran_valid  <= r_found;
            r_ran_slot   <= r_found ? pps_pkg::SLOT_W'(r_best_idx) : '0;
            r_finished   <= w_fin;
            r_turnaround <= w_fin ? (r_now_p1 - TW'(r_best.arrival)) : '0;
            r_waiting    <= w_fin ? (r_now_p1 - TW'(r_best_end)) : '0;
            r_all_done   <= (n_pend_cnt == '0);
            r_now_out    <= r_now_p1;
        end
    end

    assign o_valid      = r_valid;
    assign o_ran_valid  = r_ran_valid;
    assign o_ran_slot   = r_ran_slot;
    assign o_finished   = r_finished;
    assign o_turnaround = r_turnaround;
    assign o_waiting    = r_waiting;
    assign o_all_done   = r_all_done;
    assign o_now        = r_now_out;

endmodule

/* src/preemptive_priority_scheduler.sv */
// Top level: preemptive priority scheduler over a table of task slots.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  request  | in        | start & !busy      | i_req_type, i_slot, i_arrival, i_burst, i_prio
//  result   | out       | o_valid, one cycle | o_ran_valid, o_ran_slot, o_finished,
//           |           |                    | o_turnaround, o_waiting, o_all_done, o_now
//
//  A load request writes its slot in the load state; its result strobe is registered.
//  A tick request walks the scan state: the slot RAM is read
//  one entry per cycle to find the winner, then the update state runs it.
//  A new request may be accepted in the cycle that shows the previous result.
//  Synchronous active-low reset clears time, pending bits and the controller;
//  table contents are only used for slots that were loaded.
module preemptive_priority_scheduler #(
    parameter int SLOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_req_type,
    input  logic [pps_pkg::SLOT_W-1:0]  i_slot,
    input  logic [pps_pkg::ARR_W-1:0]   i_arrival,
    input  logic [pps_pkg::BUR_W-1:0]   i_burst,
    input  logic [pps_pkg::PRIO_W-1:0]  i_prio,
    output logic                        o_valid,
    output logic                        o_ran_valid,
    output logic [pps_pkg::SLOT_W-1:0]  o_ran_slot,
    output logic                        o_finished,
    output logic [pps_pkg::TIME_W-1:0]  o_turnaround,
    output logic [pps_pkg::TIME_W-1:0]  o_waiting,
    output logic                        o_all_done,
    output logic [pps_pkg::TIME_W-1:0]  o_now
);

    pps_pkg::t_cmd              w_cmd;
    logic [$clog2(SLOTS)-1:0]   w_rd_addr;

    // Sequencer
    pps_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .o_busy     (busy),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr)
    );

    // Table, scan and results
    pps_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_rd_addr    (w_rd_addr),
        .i_slot       (i_slot),
        .i_arrival    (i_arrival),
        .i_burst      (i_burst),
        .i_prio       (i_prio),
        .o_valid      (o_valid),
        .o_ran_valid  (o_ran_valid),
        .o_ran_slot   (o_ran_slot),
        .o_finished   (o_finished),
        .o_turnaround (o_turnaround),
        .o_waiting    (o_waiting),
        .o_all_done   (o_all_done),
        .o_now        (o_now)
    );

endmodule

/* src/pps_chk.sv */
// Port checker for the preemptive priority scheduler, bound to the top level.
module pps_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic                        o_ran_valid,
    input logic                        o_finished,
    input logic [pps_pkg::TIME_W-1:0]  o_turnaround,
    input logic [pps_pkg::TIME_W-1:0]  o_waiting
);

    // An accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    // Results appear only once the block is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Each request yields a single one-cycle result
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // Completion only for a task that ran
    a_fin_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> o_ran_valid)
        else $error("finished without a running task");

    // Times are zero unless a task completed
    a_times_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_finished) |-> (o_turnaround == '0 && o_waiting == '0))
        else $error("turnaround or waiting nonzero without completion");

endmodule

bind preemptive_priority_scheduler pps_chk u_pps_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_ran_valid  (o_ran_valid),
    .o_finished   (o_finished),
    .o_turnaround (o_turnaround),
    .o_waiting    (o_waiting)
);

/* tb/sv/preemptive_priority_scheduler_test.sv */
// Testbench: preemptive priority scheduler, checked request by request by a scoreboard.
`timescale 1ns / 100ps

module preemptive_priority_scheduler_test;

    localparam int SLOT_COUNT = 16;

    // One request as driven on the input ports
    typedef struct packed {
        logic                       kind;
        logic [pps_pkg::SLOT_W-1:0] slot;
        logic [pps_pkg::ARR_W-1:0]  arrival;
        logic [pps_pkg::BUR_W-1:0]  burst;
        logic [pps_pkg::PRIO_W-1:0] prio;
    } t_request;

    localparam int REQ_BITS = $bits(t_request);

    // One scheduling outcome as seen on the result ports
    typedef struct packed {
        logic                       ran_valid;
        logic [pps_pkg::SLOT_W-1:0] ran_slot;
        logic                       finished;
        logic [pps_pkg::TIME_W-1:0] turnaround;
        logic [pps_pkg::TIME_W-1:0] waiting;
        logic                       all_done;
        logic [pps_pkg::TIME_W-1:0] stamp;
    } t_outcome;

    // Task table model plus the queue of outcomes still owed by the block
    class t_sched_scoreboard;
        bit                         live[SLOT_COUNT];
        bit [pps_pkg::ARR_W-1:0]    arrival[SLOT_COUNT];
        bit [pps_pkg::BUR_W-1:0]    burst[SLOT_COUNT];
        bit [pps_pkg::BUR_W-1:0]    left[SLOT_COUNT];
        bit [pps_pkg::PRIO_W-1:0]   prio[SLOT_COUNT];
        bit [pps_pkg::TIME_W-1:0]   sched_now;
        t_outcome                   awaited[$];
        int                         errors;
        int                         loads;
        int                         ticks;
        int                         runs;
        int                         idles;
        int                         completions;

        // Apply an accepted request to the table and queue the outcome it owes
        function void note_request(t_request r);
            t_outcome                 e;
            bit                       found;
            int                       pick;
            bit [pps_pkg::PRIO_W-1:0] best;
            e     = '0;
            found = 1'b0;
            pick  = 0;
            best  = '0;
            if (r.kind == pps_pkg::REQ_LOAD) begin
                loads++;
                if (int'(r.slot) < SLOT_COUNT) begin
                    live[r.slot]    = 1'b1;
                    arrival[r.slot] = r.arrival;
                    burst[r.slot]   = r.burst;
                    left[r.slot]    = r.burst;
                    prio[r.slot]    = r.prio;
                end
            end else begin
                ticks++;
                // lowest priority number among arrived, unfinished tasks; low slot on ties
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (live[i] && left[i] != 0 &&
                        pps_pkg::TIME_W'(arrival[i]) <= sched_now &&
                        (!found || prio[i] < best)) begin
                        found = 1'b1;
                        best  = prio[i];
                        pick  = i;
                    end
                end
                sched_now = sched_now + 1;
                if (found) begin
                    runs++;
                    e.ran_valid = 1'b1;
                    e.ran_slot  = pps_pkg::SLOT_W'(pick);
                    left[pick]  = left[pick] - pps_pkg::BUR_W'(1);
                    if (left[pick] == 0) begin
                        completions++;
                        e.finished   = 1'b1;
                        e.turnaround = sched_now - pps_pkg::TIME_W'(arrival[pick]);
                        e.waiting    = e.turnaround - pps_pkg::TIME_W'(burst[pick]);
                    end
                end else begin
                    idles++;
                end
            end
            e.all_done = 1'b1;
            for (int i = 0; i < SLOT_COUNT; i++)
                if (live[i] && left[i] != 0) e.all_done = 1'b0;
            e.stamp = sched_now;
            awaited.push_back(e);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        // Compare one strobed outcome with the oldest one owed
        function void check_outcome(t_outcome got);
            t_outcome want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result strobe: expected none, actual now=%0h",
                         $time, got.stamp);
                return;
            end
            want = awaited.pop_front();
            compare_field("ran_valid",  32'(want.ran_valid),  32'(got.ran_valid));
            compare_field("ran_slot",   32'(want.ran_slot),   32'(got.ran_slot));
            compare_field("finished",   32'(want.finished),   32'(got.finished));
            compare_field("turnaround", want.turnaround,      got.turnaround);
            compare_field("waiting",    want.waiting,         got.waiting);
            compare_field("all_done",   32'(want.all_done),   32'(got.all_done));
            compare_field("now",        want.stamp,           got.stamp);
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic                         i_req_type;
    logic [pps_pkg::SLOT_W-1:0]   i_slot;
    logic [pps_pkg::ARR_W-1:0]    i_arrival;
    logic [pps_pkg::BUR_W-1:0]    i_burst;
    logic [pps_pkg::PRIO_W-1:0]   i_prio;
    logic                         o_valid;
    logic                         o_ran_valid;
    logic [pps_pkg::SLOT_W-1:0]   o_ran_slot;
    logic                         o_finished;
    logic [pps_pkg::TIME_W-1:0]   o_turnaround;
    logic [pps_pkg::TIME_W-1:0]   o_waiting;
    logic                         o_all_done;
    logic [pps_pkg::TIME_W-1:0]   o_now;

    t_sched_scoreboard   sb;
    bit                  no_idle;
    int                  sent;

    preemptive_priority_scheduler #(.SLOTS(SLOT_COUNT)) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_slot       (i_slot),
        .i_arrival    (i_arrival),
        .i_burst      (i_burst),
        .i_prio       (i_prio),
        .o_valid      (o_valid),
        .o_ran_valid  (o_ran_valid),
        .o_ran_slot   (o_ran_slot),
        .o_finished   (o_finished),
        .o_turnaround (o_turnaround),
        .o_waiting    (o_waiting),
        .o_all_done   (o_all_done),
        .o_now        (o_now)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result monitor: every strobe is checked against the oldest owed outcome
    always @(posedge i_clk) begin : result_monitor
        t_outcome got;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            got.ran_valid  = o_ran_valid;
            got.ran_slot   = o_ran_slot;
            got.finished   = o_finished;
            got.turnaround = o_turnaround;
            got.waiting    = o_waiting;
            got.all_done   = o_all_done;
            got.stamp      = o_now;
            sb.check_outcome(got);
        end
    end

    function automatic t_request make_load(int slot, int arr, int bur, int pr);
        t_request r;
        r.kind    = pps_pkg::REQ_LOAD;
        r.slot    = pps_pkg::SLOT_W'(slot);
        r.arrival = pps_pkg::ARR_W'(arr);
        r.burst   = pps_pkg::BUR_W'(bur);
        r.prio    = pps_pkg::PRIO_W'(pr);
        return r;
    endfunction

    // Tick fields other than the kind are don't-care, so they carry noise
    function automatic t_request make_tick();
        t_request r;
        r         = t_request'(REQ_BITS'({$urandom, $urandom}));
        r.kind    = pps_pkg::REQ_TICK;
        return r;
    endfunction

    // Present one request after a random gap and hold it until accepted
    task automatic send_request(input t_request r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req_type <= r.kind;
        i_slot     <= r.slot;
        i_arrival  <= r.arrival;
        i_burst    <= r.burst;
        i_prio     <= r.prio;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(r);
        sent++;
    endtask

    task automatic drain_results();
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus: directed corner cases, then random load/tick batches with noise
    initial begin
        int       batch;
        int       base;
        int       nload;
        int       ntick;
        t_request r;
        sb         = new;
        no_idle    = 1'b0;
        sent       = 0;
        batch      = 0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_req_type <= pps_pkg::REQ_LOAD;
        i_slot     <= '0;
        i_arrival  <= '0;
        i_burst    <= '0;
        i_prio     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle tick on an empty table
        send_request(make_tick());
        // equal priorities, zero burst, a task that never arrives, a late preemptor
        send_request(make_load(0, 0, 2, 5));
        send_request(make_load(15, 0, 1, 5));
        send_request(make_load(7, 0, 0, 0));
        send_request(make_load(3, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_request(make_load(1, 3, 1, 0));
        repeat (5) send_request(make_tick());
        // reload of a pending slot, then of a running slot
        send_request(make_load(3, 0, 16'hFFFF, 8'hFF));
        send_request(make_load(2, 0, 3, 8'h80));
        send_request(make_tick());
        send_request(make_load(2, 0, 1, 8'h80));
        repeat (2) send_request(make_tick());
        send_request(make_load(3, 0, 0, 0));
        send_request(make_tick());
        send_request(make_load(9, 16'h5A5A, 16'hA5A5, 8'h0F));
        send_request(make_load(9, 16'hA5A5, 16'h5A5A, 8'hF0));
        send_request(make_load(9, 0, 0, 0));
        start <= 1'b0;
        drain_results();

        while (sent < 1100) begin
            batch++;
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                // noise: fully random requests
                repeat ($urandom_range(1, 3)) begin
                    r = t_request'(REQ_BITS'({$urandom, $urandom}));
                    send_request(r);
                end
            end else begin
                // well-formed batch: tasks arriving around now, then a run of ticks
                nload = $urandom_range(1, 4);
                ntick = $urandom_range(4, 16);
                repeat (nload) begin
                    base = int'(sb.sched_now[pps_pkg::ARR_W-1:0]) + $urandom_range(0, 8) - 3;
                    send_request(make_load($urandom_range(0, SLOT_COUNT - 1), base,
                                           ($urandom_range(0, 9) == 0) ? 0 :
                                               $urandom_range(1, 6),
                                           $urandom_range(0, 1) ? $urandom_range(0, 3) :
                                               $urandom_range(0, 255)));
                end
                repeat (ntick) send_request(make_tick());
            end
            // sender holds off until the block has answered everything
            if (batch % 12 == 0) begin
                start <= 1'b0;
                drain_results();
            end
        end
        start <= 1'b0;

        drain_results();
        repeat (SLOT_COUNT + 8) @(posedge i_clk);
        $display("Sent %0d loads and %0d ticks: %0d ran a task, %0d idle, %0d completions.",
                 sb.loads, sb.ticks, sb.runs, sb.idles, sb.completions);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* preemptive_priority_scheduler.f */
src/pps_pkg.sv
src/pps_ram.sv
src/pps_ctrl.sv
src/pps_dp.sv
src/preemptive_priority_scheduler.sv
src/pps_chk.sv
tb/sv/preemptive_priority_scheduler_test.sv
